// ===== rtl/core/vtpd_pkg.sv =====
// Shared types, widths and reset constants for the vertex transform unit.
package vtpd_pkg;

  localparam int unsigned NUM_CFG    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COMP_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DVD_W      = COMP_W + FRAC_W;
  localparam int unsigned PROD_W     = 2 * COMP_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned DIV_STEPS  = DVD_W;

  localparam logic [COMP_W-1:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [COMP_W-1:0] S32_MIN = 32'h8000_0000;

  // Identity matrix at reset
  localparam logic [63:0] CFG_RESET [NUM_CFG] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef logic [3:0][COMP_W-1:0] vec_t;
  typedef logic [3:0][3:0][COMP_W-1:0] mat_t;
  typedef logic [2:0][DVD_W-1:0] quot_t;

  // Transformed word plus divide control, carried alongside the divider
  typedef struct packed {
    logic dodiv;
    logic skipped;
    logic sat;
    vec_t r;
  } meta_t;

endpackage

// ===== rtl/core/vertex_transform_perspective_divide_unit.sv =====
// Top level: matrix registers, transform and divide pipelines, output register.
//
// Usage:
// - Input words (in_func, in_vx..in_vw) are taken when in_valid and in_ready
//   are high. Result words (out_ox..out_ow, out_divide_skipped,
//   out_saturated) are handed over when out_valid and out_ready are high.
// - The matrix is written through cfg_valid/cfg_ready with cfg_index 0..7
//   and 64-bit cfg_data; cfg_ready is always high. Write only while idle.
// - Every result goes through all stages: one product stage, one sum and
//   clamp stage, 48 divider stages (one quotient bit each, from the 48-bit
//   scaled dividend) and the output register.
// - Throughput is one vertex per cycle while no stalled output word holds it.
// - Reset loads the identity matrix and clears all valid bits.
// - While out_valid is high and out_ready low, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated.
module vertex_transform_perspective_divide_unit
  import vtpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [COMP_W-1:0]    in_vx,
  input  logic [COMP_W-1:0]    in_vy,
  input  logic [COMP_W-1:0]    in_vz,
  input  logic [COMP_W-1:0]    in_vw,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COMP_W-1:0]    out_ox,
  output logic [COMP_W-1:0]    out_oy,
  output logic [COMP_W-1:0]    out_oz,
  output logic [COMP_W-1:0]    out_ow,
  output logic                 out_divide_skipped,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [63:0] cfg_r [NUM_CFG];
  mat_t        mat;
  vec_t        vec;
  logic        adv;
  logic        mac_valid, div_valid;
  meta_t       mac_meta, div_meta;
  quot_t       div_quot;
  logic        out_valid_r;
  vec_t        res_r, res_nxt;
  logic        skip_r, skip_nxt, sat_r, sat_nxt;

  // Matrix registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) cfg_r[i] <= CFG_RESET[i];
    end else if (cfg_valid) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // Unpack coefficients: column c, rows 0/1 in even register, rows 2/3 in odd
  always_comb begin
    for (int rr = 0; rr < 4; rr++) begin
      for (int cc = 0; cc < 4; cc++) begin
        mat[rr][cc] = cfg_r[cc*2 + rr/2][(rr%2)*COMP_W +: COMP_W];
      end
    end
  end

  assign vec = {in_vw, in_vz, in_vy, in_vx};

  // Hold everything while the output word waits
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  vtpd_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_vec    (vec),
    .mat       (mat),
    .out_valid (mac_valid),
    .out_meta  (mac_meta)
  );

  vtpd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (mac_valid),
    .in_meta   (mac_meta),
    .out_valid (div_valid),
    .out_meta  (div_meta),
    .out_quot  (div_quot)
  );

  // Apply signs, clamp quotients, pick divided or plain values
  always_comb begin
    logic                neg;
    logic                qsat;
    logic [DVD_W-1:0]    q;
    res_nxt  = div_meta.r;
    skip_nxt = div_meta.skipped;
    sat_nxt  = div_meta.sat;
    for (int l = 0; l < 3; l++) begin
      q   = div_quot[l];
      neg = div_meta.r[l][COMP_W-1] ^ div_meta.r[3][COMP_W-1];
      if (neg) begin
        qsat = (|q[DVD_W-1:COMP_W]) || (q[COMP_W-1] && (|q[COMP_W-2:0]));
      end else begin
        qsat = |q[DVD_W-1:COMP_W-1];
      end
      if (div_meta.dodiv) begin
        if (qsat) begin
          res_nxt[l] = neg ? S32_MIN : S32_MAX;
          sat_nxt    = 1'b1;
        end else begin
          res_nxt[l] = neg ? (~q[COMP_W-1:0] + 1'b1) : q[COMP_W-1:0];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= res_nxt;
      skip_r <= skip_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ox             = res_r[0];
  assign out_oy             = res_r[1];
  assign out_oz             = res_r[2];
  assign out_ow             = res_r[3];
  assign out_divide_skipped = skip_r;
  assign out_saturated      = sat_r;

  // A skipped divide means the transformed w was zero
  a_skip_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_skipped |-> out_ow == '0)
    else $error("divide skipped with nonzero w");

  // No word appears right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A waiting word is held by the stall logic
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && !in_ready == !out_ready)
    else $error("stalled word dropped");

endmodule

// ===== rtl/core/vtpd_mac.sv =====
// Matrix-vector multiply: product stage, then sum, shift and saturate stage.
module vtpd_mac
  import vtpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_valid,
  input  logic  in_func,
  input  vec_t  in_vec,
  input  mat_t  mat,
  output logic  out_valid,
  output meta_t out_meta
);

  logic                          vld1_r, vld2_r;
  logic                          func1_r;
  logic [3:0][3:0][PROD_W-1:0]   prod_r;
  meta_t                         meta_r, meta_nxt;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  // Form the sixteen full products
  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r <= in_func;
      for (int rr = 0; rr < 4; rr++) begin
        for (int cc = 0; cc < 4; cc++) begin
          prod_r[rr][cc] <= PROD_W'($signed(mat[rr][cc]) * $signed(in_vec[cc]));
        end
      end
    end
  end

  // Sum each row, floor-shift by the fraction width, clamp to 32 bits
  always_comb begin
    logic signed [SUM_W-1:0]        sum;
    logic signed [SUM_W-FRAC_W-1:0] sh;
    logic                           fits;
    meta_nxt = '0;
    for (int rr = 0; rr < 4; rr++) begin
      sum = SUM_W'($signed(prod_r[rr][0])) + SUM_W'($signed(prod_r[rr][1]))
          + SUM_W'($signed(prod_r[rr][2])) + SUM_W'($signed(prod_r[rr][3]));
      sh  = sum[SUM_W-1:FRAC_W];
      fits = (&sh[SUM_W-FRAC_W-1:COMP_W-1]) || !(|sh[SUM_W-FRAC_W-1:COMP_W-1]);
      if (fits) begin
        meta_nxt.r[rr] = sh[COMP_W-1:0];
      end else begin
        meta_nxt.r[rr] = sh[SUM_W-FRAC_W-1] ? S32_MIN : S32_MAX;
        meta_nxt.sat   = 1'b1;
      end
    end
    meta_nxt.dodiv   = func1_r && (meta_nxt.r[3] != '0);
    meta_nxt.skipped = func1_r && (meta_nxt.r[3] == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r <= meta_nxt;
    end
  end

  assign out_valid = vld2_r;
  assign out_meta  = meta_r;

endmodule

// ===== rtl/core/vtpd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes.
module vtpd_div
  import vtpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_valid,
  input  meta_t in_meta,
  output logic  out_valid,
  output meta_t out_meta,
  output quot_t out_quot
);

  typedef struct packed {
    logic [COMP_W-1:0] rem;
    logic [DVD_W-1:0]  dq;
  } lane_t;

  function automatic lane_t div_step(lane_t cur, logic [COMP_W-1:0] d);
    logic [COMP_W:0] t;
    logic [COMP_W:0] diff;
    lane_t           res;
    t    = {cur.rem, cur.dq[DVD_W-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      res.rem = diff[COMP_W-1:0];
      res.dq  = {cur.dq[DVD_W-2:0], 1'b1};
    end else begin
      res.rem = t[COMP_W-1:0];
      res.dq  = {cur.dq[DVD_W-2:0], 1'b0};
    end
    return res;
  endfunction

  logic              vld_r  [DIV_STEPS];
  meta_t             meta_r [DIV_STEPS];
  logic [COMP_W-1:0] dvs_r  [DIV_STEPS];
  lane_t             lane_r [DIV_STEPS][3];

  logic [COMP_W-1:0] dvs_in;
  lane_t             lane_in [3];

  // Magnitudes of divisor and scaled dividends
  always_comb begin
    dvs_in = in_meta.r[3][COMP_W-1] ? (~in_meta.r[3] + 1'b1) : in_meta.r[3];
    for (int l = 0; l < 3; l++) begin
      lane_in[l].rem = '0;
      lane_in[l].dq  = {(in_meta.r[l][COMP_W-1] ? (~in_meta.r[l] + 1'b1) : in_meta.r[l]),
                        {FRAC_W{1'b0}}};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STEPS; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < DIV_STEPS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // Advance data, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= in_meta;
      dvs_r[0]  <= dvs_in;
      for (int l = 0; l < 3; l++) lane_r[0][l] <= div_step(lane_in[l], dvs_in);
      for (int s = 1; s < DIV_STEPS; s++) begin
        meta_r[s] <= meta_r[s-1];
        dvs_r[s]  <= dvs_r[s-1];
        for (int l = 0; l < 3; l++) lane_r[s][l] <= div_step(lane_r[s-1][l], dvs_r[s-1]);
      end
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_meta  = meta_r[DIV_STEPS-1];
  always_comb begin
    for (int l = 0; l < 3; l++) out_quot[l] = lane_r[DIV_STEPS-1][l].dq;
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for the vertex transform and perspective divide unit.
`timescale 1ns / 100ps

module tb;
  import vtpd_pkg::*;

  localparam logic FUNC_PLAIN  = 1'b0;
  localparam logic FUNC_DIVIDE = 1'b1;
  localparam int   DRAIN_CYCLES = 60;
  localparam int   CYCLE_LIMIT  = 500000;
  localparam longint Q32_MAX = 64'sd2147483647;
  localparam longint Q32_MIN = -64'sd2147483648;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE_Q = 32'hffff_0000;

  typedef struct {
    logic [COMP_W-1:0] ox, oy, oz, ow;
    logic divide_skipped;
    logic saturated;
  } vertex_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [COMP_W-1:0] in_vx = '0, in_vy = '0, in_vz = '0, in_vw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COMP_W-1:0] out_ox, out_oy, out_oz, out_ow;
  logic out_divide_skipped, out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] matrix_regs [NUM_CFG];
  vertex_result_t pending_results [$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 1;
  int stall_tick = 0;
  int stall_mode = 0;

  vertex_transform_perspective_divide_unit i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Saturate to signed 32 bits, flagging any clamp
  function automatic longint clamp_q32(longint value, inout logic sat);
    if (value > Q32_MAX) begin
      sat = 1'b1;
      return Q32_MAX;
    end
    if (value < Q32_MIN) begin
      sat = 1'b1;
      return Q32_MIN;
    end
    return value;
  endfunction

  // Transform one vertex by the shadow matrix, then divide if asked
  function automatic vertex_result_t transform_vertex(logic func, logic [31:0] vx,
      logic [31:0] vy, logic [31:0] vz, logic [31:0] vw);
    logic signed [31:0] comp [4];
    logic signed [31:0] cf;
    logic signed [63:0] prod;
    logic signed [65:0] acc;
    logic signed [65:0] shifted;
    longint rows [4];
    logic [63:0] reg_word;
    logic sat;
    vertex_result_t res;
    comp[0] = vx; comp[1] = vy; comp[2] = vz; comp[3] = vw;
    sat = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        reg_word = matrix_regs[c * 2 + r / 2];
        cf = (r % 2) ? reg_word[63:32] : reg_word[31:0];
        prod = cf * comp[c];
        acc = acc + prod;
      end
      shifted = acc >>> FRAC_W;
      rows[r] = clamp_q32(longint'(shifted), sat);
    end
    res.divide_skipped = 1'b0;
    if (func == FUNC_DIVIDE) begin
      if (rows[3] == 0) begin
        res.divide_skipped = 1'b1;
      end else begin
        for (int r = 0; r < 3; r++)
          rows[r] = clamp_q32((rows[r] * 65536) / rows[3], sat);
      end
    end
    res.ox = rows[0][31:0];
    res.oy = rows[1][31:0];
    res.oz = rows[2][31:0];
    res.ow = rows[3][31:0];
    res.saturated = sat;
    return res;
  endfunction

  // Offer one vertex and hold it until taken; open a random gap between bursts
  task automatic send_vertex(logic func, logic [31:0] vx, logic [31:0] vy,
      logic [31:0] vz, logic [31:0] vw);
    vertex_result_t exp_res;
    int gap;
    exp_res = transform_vertex(func, vx, vy, vz, vw);
    in_valid <= 1'b1;
    in_func <= func;
    in_vx <= vx; in_vy <= vy; in_vz <= vz; in_vw <= vw;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(exp_res);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Wait until every result is back and the pipeline has emptied
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight matrix registers while idle
  task automatic load_matrix(logic [63:0] words [NUM_CFG]);
    wait_idle();
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= words[i];
      do @(posedge clk); while (!cfg_ready);
      matrix_regs[i] = words[i];
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 262143) - 32'd131072;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? ONE_Q : NEG_ONE_Q;
      default: return $urandom_range(0, 33554431) - 32'd16777216;
    endcase
  endfunction

  task automatic fill_matrix(logic [31:0] coef);
    logic [63:0] words [NUM_CFG];
    for (int i = 0; i < NUM_CFG; i++) words[i] = {coef, coef};
    load_matrix(words);
  endtask

  task automatic test_identity_extremes();
    send_vertex(FUNC_PLAIN, 32'h7fff_ffff, 32'h8000_0000, 32'h0, ONE_Q);
    send_vertex(FUNC_PLAIN, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
    send_vertex(FUNC_DIVIDE, 32'h0003_0000, 32'hfffe_0000, 32'h0000_8000, 32'h0);
    send_vertex(FUNC_DIVIDE, 32'h0003_0000, 32'hfffe_0000, 32'h0000_8000, ONE_Q);
    send_vertex(FUNC_DIVIDE, 32'h0003_0000, 32'hfffe_0000, 32'h0000_8000, NEG_ONE_Q);
    send_vertex(FUNC_DIVIDE, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h1);
    send_vertex(FUNC_DIVIDE, 32'h0000_0007, 32'hffff_fff9, 32'h0000_0001, 32'h0003_0000);
    send_vertex(FUNC_DIVIDE, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff);
    send_vertex(FUNC_DIVIDE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(FUNC_PLAIN, 32'h0, 32'h0, 32'h0, 32'h0);
    send_vertex(FUNC_DIVIDE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
  endtask

  task automatic test_saturation();
    fill_matrix(32'h7fff_ffff);
    send_vertex(FUNC_PLAIN, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(FUNC_DIVIDE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(FUNC_DIVIDE, 32'h1, 32'h0, 32'h0, 32'h0);
    fill_matrix(32'h8000_0000);
    send_vertex(FUNC_PLAIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(FUNC_DIVIDE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(FUNC_DIVIDE, 32'h0000_0002, 32'h0, 32'h0, 32'h0);
    fill_matrix(32'h0);
    send_vertex(FUNC_DIVIDE, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h1);
    send_vertex(FUNC_PLAIN, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h1);
  endtask

  // Random matrix per phase, random vertices of mixed magnitude
  task automatic test_random_phases(int phases, int per_phase);
    logic [63:0] words [NUM_CFG];
    for (int p = 0; p < phases; p++) begin
      for (int i = 0; i < NUM_CFG; i++) words[i] = {random_value(), random_value()};
      load_matrix(words);
      for (int n = 0; n < per_phase; n++)
        send_vertex($urandom_range(0, 3) != 0 ? FUNC_DIVIDE : FUNC_PLAIN,
                    random_value(), random_value(), random_value(), random_value());
    end
  endtask

  // Receiver stall pattern, switching between four styles at random
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= (stall_tick % 9) >= 4;
      default: out_ready <= $urandom_range(0, 7) != 0;
    endcase
  end

  // Compare each handed-over word with the oldest expectation
  always @(posedge clk) begin
    vertex_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word ox=%h", out_ox);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ox !== exp_res.ox || out_oy !== exp_res.oy || out_oz !== exp_res.oz ||
            out_ow !== exp_res.ow || out_divide_skipped !== exp_res.divide_skipped ||
            out_saturated !== exp_res.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %h skip=%b sat=%b got %h %h %h %h skip=%b sat=%b",
                     exp_res.ox, exp_res.oy, exp_res.oz, exp_res.ow,
                     exp_res.divide_skipped, exp_res.saturated, out_ox, out_oy, out_oz,
                     out_ow, out_divide_skipped, out_saturated);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_CFG; i++) matrix_regs[i] = CFG_RESET[i];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_extremes();
    test_saturation();
    test_random_phases(6, 190);
    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
